>>> sv/jpe_pkg.sv
// Shared types and constants for the Jacobi polynomial evaluator.
// Used by jpe_qmul, jpe_div_cell, jpe_qdiv and jacobi_polynomial_eval.
package jpe_pkg;

	localparam int MAX_DEGREE = 32;
	localparam int KW = $clog2(MAX_DEGREE + 2);
	localparam int DIV_CELLS = 4;
	localparam int DIV_STEPS = 96;
	localparam int DIV_PASSES = DIV_STEPS / DIV_CELLS;
	localparam int DCW = $clog2(DIV_PASSES + 1);

	localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] HALF_Q32 = 64'sh0000_0000_8000_0000;
	localparam logic signed [63:0] MAX_Q = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] RES_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] RES_MIN = -64'sh0000_8000_0000_0000;

	localparam logic [1:0] REG_DEGREE = 2'd0;
	localparam logic [1:0] REG_ALPHA = 2'd1;
	localparam logic [1:0] REG_BETA = 2'd2;
	localparam logic [1:0] REG_SCALE = 2'd3;

	// operation request to an arithmetic unit
	typedef struct packed {
		logic start;
		logic signed [63:0] opa;
		logic signed [63:0] opb;
	} unit_req_t;

	// result returned by an arithmetic unit
	typedef struct packed {
		logic done;
		logic sat;
		logic signed [63:0] value;
	} unit_res_t;

	// magnitude of a signed Q31.32 value
	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

endpackage

>>> sv/jpe_qmul.sv
// Multi-cycle Q31.32 multiplier: four 32x32 partial products, then
// round half away from zero and saturate. Depends on jpe_pkg.
module jpe_qmul import jpe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input unit_req_t req,
	output unit_res_t res
);

	logic [63:0] xm_q, ym_q;
	logic neg_q;
	logic [127:0] acc_q;
	logic [2:0] cnt_q;
	logic busy_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] pp_sh, sum;
	logic ovf;
	logic [63:0] mag;

	// pick the partial product for this cycle
	always_comb begin
		case (cnt_q)
			3'd0: begin pa = xm_q[31:0]; pb = ym_q[31:0]; end
			3'd1: begin pa = xm_q[31:0]; pb = ym_q[63:32]; end
			3'd2: begin pa = xm_q[63:32]; pb = ym_q[31:0]; end
			default: begin pa = xm_q[63:32]; pb = ym_q[63:32]; end
		endcase
		pp = 64'(pa) * 64'(pb);
		case (cnt_q)
			3'd0: pp_sh = 128'(pp);
			3'd1, 3'd2: pp_sh = 128'(pp) << 32;
			default: pp_sh = 128'(pp) << 64;
		endcase
	end

	// round, saturate and apply sign
	always_comb begin
		sum = acc_q + 128'h8000_0000;
		ovf = |sum[127:96];
		mag = ovf ? '1 : sum[95:32];
		res.done = busy_q && (cnt_q == 3'd4);
		res.sat = ovf || mag[63];
		if (mag[63])
			mag = 64'(MAX_Q);
		res.value = neg_q ? -$signed(mag) : $signed(mag);
	end

	// accumulate partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			xm_q <= mag64(req.opa);
			ym_q <= mag64(req.opb);
			neg_q <= req.opa[63] ^ req.opb[63];
			acc_q <= '0;
		end else if (busy_q && cnt_q != 3'd4) begin
			acc_q <= acc_q + pp_sh;
		end
	end

endmodule

>>> sv/jpe_div_cell.sv
// One restoring division step: shift in a numerator bit, compare, subtract.
// Depends on jpe_pkg only for the import convention.
module jpe_div_cell import jpe_pkg::*; (
	input logic [63:0] den,
	input logic nbit,
	input logic [63:0] rem_in,
	input logic [63:0] quo_in,
	input logic big_in,
	output logic [63:0] rem_out,
	output logic [63:0] quo_out,
	output logic big_out
);

	logic [63:0] r2;

	always_comb begin
		r2 = {rem_in[62:0], nbit};
		big_out = big_in | quo_in[63];
		quo_out = {quo_in[62:0], 1'b0};
		rem_out = r2;
		if (r2 >= den) begin
			rem_out = r2 - den;
			quo_out[0] = 1'b1;
		end
	end

endmodule

>>> sv/jpe_qdiv.sv
// Q31.32 divider: a chain of division cells, one pass per cycle, then
// round half away from zero. Depends on jpe_pkg and jpe_div_cell.
module jpe_qdiv import jpe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input unit_req_t req,
	output unit_res_t res
);

	logic [95:0] num_q;
	logic [63:0] den_q, rem_q, quo_q;
	logic big_q, neg_q, zero_q, busy_q;
	logic [DCW-1:0] cnt_q;
	logic [63:0] rem_c [DIV_CELLS+1];
	logic [63:0] quo_c [DIV_CELLS+1];
	logic big_c [DIV_CELLS+1];
	logic [63:0] qr, mag;
	logic bg;

	assign rem_c[0] = rem_q;
	assign quo_c[0] = quo_q;
	assign big_c[0] = big_q;

	// row of cells, each taking the next numerator bit
	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_cell
		jpe_div_cell u_cell (
			.den(den_q),
			.nbit(num_q[95-j]),
			.rem_in(rem_c[j]),
			.quo_in(quo_c[j]),
			.big_in(big_c[j]),
			.rem_out(rem_c[j+1]),
			.quo_out(quo_c[j+1]),
			.big_out(big_c[j+1])
		);
	end

	// final rounding and sign
	always_comb begin
		bg = big_q;
		qr = quo_q;
		if (rem_q >= den_q - rem_q) begin
			if (&quo_q)
				bg = 1'b1;
			else
				qr = quo_q + 64'd1;
		end
		mag = bg ? '1 : qr;
		res.done = busy_q && (cnt_q == DCW'(DIV_PASSES));
		res.sat = zero_q || mag[63];
		if (mag[63])
			mag = 64'(MAX_Q);
		if (zero_q)
			res.value = '0;
		else
			res.value = neg_q ? -$signed(mag) : $signed(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == DCW'(DIV_PASSES))
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + DCW'(1);
		end
	end

	// advance the chain by one pass
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {mag64(req.opa), 32'd0};
			den_q <= mag64(req.opb);
			neg_q <= req.opa[63] ^ req.opb[63];
			zero_q <= (req.opb == '0);
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q && cnt_q != DCW'(DIV_PASSES)) begin
			num_q <= num_q << DIV_CELLS;
			rem_q <= rem_c[DIV_CELLS];
			quo_q <= quo_c[DIV_CELLS];
			big_q <= big_c[DIV_CELLS];
		end
	end

endmodule

>>> sv/jacobi_polynomial_eval.sv
// Normalized Jacobi polynomial evaluator, top level with the recurrence sequencer.
// Depends on jpe_pkg, jpe_qmul and jpe_qdiv.
//
// Usage: write degree (0), alpha_q16 (1), beta_q16 (2) and norm_scale (3)
// through cfg_we/cfg_addr/cfg_data while the block is idle. Each point item on
// the s_ stream yields one item on the m_ stream: value (Q16.32, saturated)
// and an overflow flag. Degrees above 32 are clamped to 32.
// Every product runs on the shared multiplier, every quotient on the
// divider chain (4 cells, 24 passes). The first order term takes 2
// products, each recurrence step 12 products and one quotient, the
// final scaling one product. One item is worked at a time; s_tready
// rises again once the result is placed in the output
// register. The output register holds its item while m_tready is low, and
// the next point may already be taken and computed meanwhile; the sequencer
// waits only if a new result is ready while the old one still stands.
// Reset clears the registers to degree 0, alpha 0, beta 0, scale 1.0 and
// empties the output register.
module jacobi_polynomial_eval import jpe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_addr,
	input logic [31:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // [31:0] point
	output logic m_tvalid,
	input logic m_tready,
	output logic [55:0] m_tdata // [47:0] value, [48] overflow, rest zero
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_HOLD} state_t;
	typedef enum logic [3:0] {
		OP_P1A, OP_P1B, OP_M1, OP_DEN, OP_M2, OP_M3, OP_AA, OP_BB, OP_G1,
		OP_M4, OP_M5, OP_G0, OP_P1, OP_P2, OP_DIV, OP_FIN
	} op_t;

	state_t state_q;
	op_t op_q;
	logic [5:0] degree_q;
	logic [21:0] alpha_q, beta_q;
	logic [31:0] scale_q;
	logic signed [63:0] x_q, a_q, b_q, s_q;
	logic signed [63:0] y0_q, y1_q, t_q, u_q, v_q, g1_q, den_q;
	logic [KW-1:0] k_q, n_q;
	logic sat_q;
	logic [47:0] val_q;
	logic ovf_q, mv_q;
	unit_req_t mreq, dreq;
	unit_res_t mres, dres, ures;
	logic signed [63:0] kq, t2, t1, t0, opa, opb, r, inner, fin;
	logic sat_w, fsat;

	// saturating add, symmetric limits
	function automatic logic [64:0] sadd(input logic signed [63:0] p,
			input logic signed [63:0] q);
		logic signed [64:0] w;
		w = 65'(p) + 65'(q);
		if (w > 65'(MAX_Q))
			sadd = {1'b1, MAX_Q};
		else if (w < -65'(MAX_Q))
			sadd = {1'b1, -MAX_Q};
		else
			sadd = {1'b0, w[63:0]};
	endfunction

	assign kq = 64'(k_q) << 32;
	assign t2 = 2 * kq + s_q;
	assign t1 = t2 - ONE_Q32;
	assign t0 = t2 - 2 * ONE_Q32;
	assign ures = (op_q == OP_DIV) ? dres : mres;
	assign r = ures.value;

	// operand select per operation
	always_comb begin
		case (op_q)
			OP_P1A: begin opa = s_q + 2 * ONE_Q32; opb = x_q - ONE_Q32; end
			OP_P1B: begin opa = t_q; opb = HALF_Q32; end
			OP_M1: begin opa = 2 * kq; opb = kq + s_q; end
			OP_DEN: begin opa = t_q; opb = t0; end
			OP_M2: begin opa = t2; opb = t0; end
			OP_M3: begin opa = t_q; opb = x_q; end
			OP_AA: begin opa = a_q; opb = a_q; end
			OP_BB: begin opa = b_q; opb = b_q; end
			OP_G1: begin opa = t1; opb = u_q; end
			OP_M4: begin opa = kq + a_q - ONE_Q32; opb = kq + b_q - ONE_Q32; end
			OP_M5: begin opa = t_q; opb = t2; end
			OP_G0: begin opa = -2 * ONE_Q32; opb = t_q; end
			OP_P1: begin opa = g1_q; opb = y1_q; end
			OP_P2: begin opa = t_q; opb = y0_q; end
			OP_DIV: begin opa = u_q; opb = den_q; end
			default: begin opa = y1_q; opb = 64'({scale_q, 8'd0}); end
		endcase
		mreq.start = (state_q == S_RUN) && (op_q != OP_DIV);
		mreq.opa = opa;
		mreq.opb = opb;
		dreq.start = (state_q == S_RUN) && (op_q == OP_DIV);
		dreq.opa = opa;
		dreq.opb = opb;
	end

	jpe_qmul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .res(mres));
	jpe_qdiv u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .res(dres));

	// saturating sums and final clamp
	always_comb begin
		logic [64:0] s1, s2;
		s1 = sadd(v_q, -r);
		s2 = sadd(u_q, s1[63:0]);
		inner = s2[63:0];
		sat_w = s1[64] | s2[64];
		fin = r;
		fsat = 1'b0;
		if (r > RES_MAX) begin
			fin = RES_MAX;
			fsat = 1'b1;
		end else if (r < RES_MIN) begin
			fin = RES_MIN;
			fsat = 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			alpha_q <= '0;
			beta_q <= '0;
			scale_q <= 32'd16777216;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DEGREE: degree_q <= cfg_data[5:0];
				REG_ALPHA: alpha_q <= cfg_data[21:0];
				REG_BETA: beta_q <= cfg_data[21:0];
				REG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mv_q;
	assign m_tdata = {7'd0, ovf_q, val_q};

	// sequencer: state, operation, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		logic [64:0] sp;
		logic step_sat;
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_P1A;
			k_q <= '0;
			n_q <= '0;
			sat_q <= 1'b0;
			mv_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						x_q <= 64'($signed(s_tdata)) <<< 2;
						a_q <= 64'($signed(alpha_q)) <<< 16;
						b_q <= 64'($signed(beta_q)) <<< 16;
						s_q <= (64'($signed(alpha_q)) + 64'($signed(beta_q))) <<< 16;
						if (int'(degree_q) > MAX_DEGREE)
							n_q <= KW'(MAX_DEGREE);
						else
							n_q <= KW'(degree_q);
						k_q <= KW'(2);
						sat_q <= 1'b0;
						op_q <= OP_P1A;
						state_q <= S_RUN;
					end
				end
				S_RUN: state_q <= S_WAIT;
				S_WAIT: begin
					if (ures.done) begin
						step_sat = ures.sat;
						state_q <= (op_q == OP_FIN) ? S_HOLD : S_RUN;
						case (op_q)
							OP_P1A: begin t_q <= r; op_q <= OP_P1B; end
							OP_P1B: begin
								sp = sadd(a_q + ONE_Q32, r);
								step_sat = step_sat | sp[64];
								y1_q <= (n_q == '0) ? ONE_Q32 : sp[63:0];
								y0_q <= ONE_Q32;
								op_q <= (n_q < KW'(2)) ? OP_FIN : OP_M1;
							end
							OP_M1: begin t_q <= r; op_q <= OP_DEN; end
							OP_DEN: begin den_q <= r; op_q <= OP_M2; end
							OP_M2: begin t_q <= r; op_q <= OP_M3; end
							OP_M3: begin u_q <= r; op_q <= OP_AA; end
							OP_AA: begin v_q <= r; op_q <= OP_BB; end
							OP_BB: begin
								u_q <= inner;
								step_sat = step_sat | sat_w;
								op_q <= OP_G1;
							end
							OP_G1: begin g1_q <= r; op_q <= OP_M4; end
							OP_M4: begin t_q <= r; op_q <= OP_M5; end
							OP_M5: begin t_q <= r; op_q <= OP_G0; end
							OP_G0: begin t_q <= r; op_q <= OP_P1; end
							OP_P1: begin u_q <= r; op_q <= OP_P2; end
							OP_P2: begin
								sp = sadd(u_q, r);
								u_q <= sp[63:0];
								step_sat = step_sat | sp[64];
								op_q <= OP_DIV;
							end
							OP_DIV: begin
								y0_q <= y1_q;
								y1_q <= r;
								k_q <= k_q + KW'(1);
								op_q <= (k_q == n_q) ? OP_FIN : OP_M1;
							end
							default: begin
								// hold the clamped result until the output register frees
								t_q <= fin;
								step_sat = step_sat | fsat;
							end
						endcase
						sat_q <= sat_q | step_sat;
					end
				end
				default: begin
					// drop the result into the output register once it is free
					if (!mv_q || m_tready) begin
						val_q <= t_q[47:0];
						ovf_q <= sat_q;
						state_q <= S_IDLE;
					end
				end
			endcase
			// raise valid on load, lower it once the item is taken
			if (state_q == S_HOLD && (!mv_q || m_tready))
				mv_q <= 1'b1;
			else if (mv_q && m_tready)
				mv_q <= 1'b0;
		end
	end

	// only one arithmetic unit finishes at a time
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mres.done && dres.done))
		else $error("multiplier and divider finished together");

	// step counter stays at most one above the maximum degree
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(k_q) <= MAX_DEGREE + 1)
		else $error("recurrence step beyond maximum degree");

	// an accepted item blocks further input until its result is placed
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in work");

	// the output register is loaded only from the hold state
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_HOLD))
		else $error("result presented without a finished item");

endmodule

>>> tb/jacobi_polynomial_eval_test.sv
// Self-checking test of the Jacobi polynomial evaluator: random and edge points
// under several register settings, each result checked against a bit-true model.
// Depends on jpe_pkg and jacobi_polynomial_eval.
module jacobi_polynomial_eval_test;
	import jpe_pkg::*;

	localparam logic signed [63:0] ONE_Q = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] TOP_Q = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic overflow;
		logic [47:0] value;
	} poly_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;

	// shadow copy of the register file
	logic [5:0] deg_reg = 6'd0;
	logic [21:0] alpha_reg = '0;
	logic [21:0] beta_reg = '0;
	logic [31:0] scale_reg = 32'd16777216;

	poly_result_t pending_values[$];
	int error_count = 0;
	int points_sent = 0;
	int values_seen = 0;
	int overflow_seen = 0;
	int sink_wait = 0;
	int sink_seen = 0;
	bit sat_flag;
	bit sink_busy = 1'b1;

	jacobi_polynomial_eval dut (.*);

	always #5 clk = ~clk;

	initial begin
		#200_000_000;
		$display("jacobi_polynomial_eval_test: errors");
		$finish;
	end

	task automatic report(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	// saturating arithmetic on Q31.32 values
	function automatic logic signed [63:0] signed_from_mag(input bit neg, input logic [63:0] m);
		logic [63:0] mm;
		mm = m;
		if (mm > 64'h7FFF_FFFF_FFFF_FFFF) begin
			sat_flag = 1'b1;
			mm = 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return neg ? -$signed(mm) : $signed(mm);
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] t;
		t = 65'(a) + 65'(b);
		if (t > 65'(TOP_Q)) begin
			sat_flag = 1'b1;
			return TOP_Q;
		end
		if (t < -65'(TOP_Q)) begin
			sat_flag = 1'b1;
			return -TOP_Q;
		end
		return t[63:0];
	endfunction

	function automatic logic [63:0] abs_of(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] mul_q(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [127:0] p;
		logic [63:0] r;
		p = abs_of(a) * abs_of(b) + 128'h8000_0000;
		if (p[127:96] != 0) begin
			sat_flag = 1'b1;
			r = '1;
		end else
			r = p[95:32];
		return signed_from_mag(a[63] != b[63], r);
	endfunction

	function automatic logic signed [63:0] div_q(input logic signed [63:0] num,
			input logic signed [63:0] den);
		logic [127:0] n, q;
		logic [63:0] d;
		logic [127:0] rem;
		logic [63:0] r;
		if (den == 0) begin
			sat_flag = 1'b1;
			return 0;
		end
		n = {32'd0, abs_of(num), 32'd0};
		d = abs_of(den);
		q = n / d;
		rem = n % d;
		if (rem >= 128'(d) - rem)
			q = q + 1;
		if (q[127:64] != 0)
			r = '1;
		else
			r = q[63:0];
		if (q[127:64] != 0)
			sat_flag = 1'b1;
		return signed_from_mag(num[63] != den[63], r);
	endfunction

	// evaluate the scaled polynomial at one point
	function automatic poly_result_t jacobi_value(input logic [31:0] pt);
		logic signed [63:0] x, a, b, s, y0, y1, yk, res, kq, t0, t1, t2, den, inner,
			g1, g0, num;
		int n;
		poly_result_t r;
		sat_flag = 1'b0;
		x = 64'($signed(pt)) * 4;
		a = 64'($signed(alpha_reg)) * 65536;
		b = 64'($signed(beta_reg)) * 65536;
		s = a + b;
		n = deg_reg > MAX_DEGREE ? MAX_DEGREE : deg_reg;
		y0 = ONE_Q;
		y1 = add_sat(a + ONE_Q, mul_q(mul_q(s + 2 * ONE_Q, x - ONE_Q), ONE_Q / 2));
		yk = (n == 0) ? ONE_Q : y1;
		for (int k = 2; k <= n; k++) begin
			kq = 64'(k) <<< 32;
			t0 = 2 * kq + s - 2 * ONE_Q;
			t1 = 2 * kq + s - ONE_Q;
			t2 = 2 * kq + s;
			den = mul_q(mul_q(2 * kq, kq + s), t0);
			inner = add_sat(mul_q(mul_q(t2, t0), x), add_sat(mul_q(a, a), -mul_q(b, b)));
			g1 = mul_q(t1, inner);
			g0 = mul_q(-2 * ONE_Q, mul_q(mul_q(kq + a - ONE_Q, kq + b - ONE_Q), t2));
			num = add_sat(mul_q(g1, y1), mul_q(g0, y0));
			yk = div_q(num, den);
			y0 = y1;
			y1 = yk;
		end
		res = mul_q(yk, 64'(scale_reg) * 256);
		if (res > RES_MAX) begin
			res = RES_MAX;
			sat_flag = 1'b1;
		end else if (res < RES_MIN) begin
			res = RES_MIN;
			sat_flag = 1'b1;
		end
		r.value = res[47:0];
		r.overflow = sat_flag;
		return r;
	endfunction

	// write one register while idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEGREE: deg_reg = val[5:0];
			REG_ALPHA: alpha_reg = val[21:0];
			REG_BETA: beta_reg = val[21:0];
			REG_SCALE: scale_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_params(input logic [5:0] n, input int alpha, input int beta,
			input logic [31:0] scale);
		write_reg(REG_DEGREE, 32'(n));
		write_reg(REG_ALPHA, 32'(alpha));
		write_reg(REG_BETA, 32'(beta));
		write_reg(REG_SCALE, scale);
	endtask

	// send one point, with a random gap before it
	task automatic send_point(input logic [31:0] pt);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pt;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_values.push_back(jacobi_value(pt));
		points_sent++;
		@(negedge clk);
	endtask

	// wait until every result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_values.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_point();
		case ($urandom_range(0, 5))
			0: return 32'h4000_0000;
			1: return 32'hC000_0000;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
		endcase
	endfunction

	// result sink: wait a random number of cycles before each item
	always @(negedge clk) begin
		if (values_seen != sink_seen) begin
			sink_seen = values_seen;
			sink_wait = $urandom_range(0, 9);
		end
		if (sink_busy)
			m_tready <= 1'b0;
		else if (sink_wait > 0) begin
			m_tready <= 1'b0;
			sink_wait--;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		poly_result_t want;
		if (m_tvalid && m_tready) begin
			values_seen++;
			if (pending_values.size() == 0)
				report("result with no point outstanding");
			else begin
				want = pending_values.pop_front();
				if (m_tdata[47:0] !== want.value)
					report($sformatf("value %h expected %h", m_tdata[47:0], want.value));
				if (m_tdata[48] !== want.overflow)
					report($sformatf("overflow %b expected %b", m_tdata[48], want.overflow));
				if (m_tdata[55:49] !== '0)
					report("pad bits not zero");
				if (m_tdata[48])
					overflow_seen++;
			end
		end
	end

	// points at the reset settings: P0 times 1.0
	task automatic test_reset_defaults();
		send_point(32'h4000_0000);
		send_point(32'hC000_0000);
		drain();
	endtask

	// edges: degrees 1, 32 and above, extreme alpha/beta, extreme scale
	task automatic test_directed();
		set_params(6'd1, 0, 0, 32'd16777216);
		send_point(32'h4000_0000);
		send_point(32'h0000_0000);
		send_point(32'h8000_0000);
		send_point(32'h7FFF_FFFF);
		drain();
		set_params(6'd32, -65535, 1048576, 32'hFFFF_FFFF);
		send_point(32'h4000_0000);
		send_point(32'hC000_0000);
		drain();
		set_params(6'd63, 1048576, -65535, 32'd0);
		send_point(32'h2000_0000);
		drain();
		// zero step denominator: alpha = beta = -1
		set_params(6'd3, -65536, -65536, 32'd16777216);
		send_point(32'h1000_0000);
		drain();
		// full-width parameter patterns
		set_params(6'd2, 22'h1FFFFF, 22'h200000, 32'h8000_0000);
		send_point(32'hFFFF_FFFF);
		drain();
		set_params(6'd5, 32768, 98304, 32'd33554432);
		send_point(32'hE000_0000);
		send_point(32'h3000_0000);
		drain();
	endtask

	// random settings, most with small degrees
	task automatic test_random();
		int n;
		for (int phase = 0; phase < 20; phase++) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 6);
			set_params(6'(n), $urandom_range(0, 9) == 0 ? $urandom() :
					$urandom_range(0, 300000) - 65535,
				$urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 300000) - 65535,
				$urandom_range(0, 1) ? $urandom() : 32'd16777216);
			for (int i = 0; i < 48; i++)
				send_point(rand_point());
			drain();
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		sink_busy = 1'b0;
		test_reset_defaults();
		test_directed();
		test_random();
		$display("sent %0d points over 27 register settings, %0d results, %0d with overflow",
			points_sent, values_seen, overflow_seen);
		if (error_count == 0)
			$display("jacobi_polynomial_eval_test: clean");
		else
			$display("jacobi_polynomial_eval_test: errors");
		$finish;
	end

endmodule

>>> jacobi_polynomial_eval.f
sv/jpe_pkg.sv
sv/jpe_qmul.sv
sv/jpe_div_cell.sv
sv/jpe_qdiv.sv
sv/jacobi_polynomial_eval.sv
tb/jacobi_polynomial_eval_test.sv
